@@ rtl/srrw_pkg.sv @@
package srrw_pkg;

  localparam int WINDOW_MAX  = 32;
  localparam int FRAMES_MAX  = 256;
  localparam int FRAME_BYTES = 1024;
  localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);

  localparam int SEQ_W       = 8;
  localparam int LEN_W       = 11;
  localparam int OFFSET_W    = 18;
  localparam int FLUSH_W     = 19;
  localparam int WIN_W       = 6;
  localparam int FRAMES_W    = 9;
  localparam int NEXT_W      = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_SIZE       = 2'd0,
    REG_FRAMES_PER_BUFFER = 2'd1
  } cfg_reg_t;

  // Frame descriptor as it sits in the queue between front and back.
  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic                bad;
    logic                eot;
    logic [OFFSET_W-1:0] offset;
    logic [FLUSH_W-1:0]  eot_length;
  } frame_desc_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    ack_seq;
    logic                ack_negative;
    logic                store_enable;
    logic [OFFSET_W-1:0] store_offset;
    logic                buffer_complete;
    logic [FLUSH_W-1:0]  flush_length;
    logic                transfer_done;
  } result_t;

endpackage

@@ rtl/srrw_ifs.sv @@
interface srrw_frame_if import srrw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_num;
  logic             frame_bad;
  logic             end_of_tx;
  logic [LEN_W-1:0] payload_len;

  modport source (output valid, seq_num, frame_bad, end_of_tx, payload_len, input ready);
  modport sink (input valid, seq_num, frame_bad, end_of_tx, payload_len, output ready);
endinterface

interface srrw_result_if import srrw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SEQ_W-1:0]    ack_seq;
  logic                ack_negative;
  logic                store_enable;
  logic [OFFSET_W-1:0] store_offset;
  logic                buffer_complete;
  logic [FLUSH_W-1:0]  flush_length;
  logic                transfer_done;

  modport source (output valid, ack_seq, ack_negative, store_enable, store_offset,
                  buffer_complete, flush_length, transfer_done, input ready);
  modport sink (input valid, ack_seq, ack_negative, store_enable, store_offset,
                buffer_complete, flush_length, transfer_done, output ready);
endinterface

interface srrw_cfg_if import srrw_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/selective_repeat_receive_window.sv @@
// Channel   Direction  Contents
// frame     in         seq_num, frame_bad, end_of_tx, payload_len
// result    out        ack_seq, ack_negative, store_enable, store_offset,
//                      buffer_complete, flush_length, transfer_done
// cfg       in         index, data (window_size, frames_per_buffer)
//
// One frame per cycle while results are taken and no cfg write is offered; a
// result passes the queue slot and the result register. The rate is set by the
// back end window update, a loop of run count, mask shift and pointer add.
// Synchronous reset clears the window and loads window_size 4, frames_per_buffer 1.
// A two-entry queue sits between front and back; the result register holds
// a result until it is taken, while the front keeps accepting into the queue until it is full.
module selective_repeat_receive_window import srrw_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  srrw_frame_if.sink    frame,
  srrw_result_if.source result,
  srrw_cfg_if.sink      cfg
);

  logic        push;
  logic        full;
  logic        pop;
  logic        empty;
  frame_desc_t push_desc;
  frame_desc_t pop_desc;

  srrw_front u_front (
    .frame (frame),
    .full  (full),
    .push  (push),
    .desc  (push_desc)
  );

  srrw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_desc),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_desc),
    .empty     (empty)
  );

  srrw_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .empty  (empty),
    .desc   (pop_desc),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ rtl/srrw_front.sv @@
module srrw_front import srrw_pkg::*; (
  srrw_frame_if.sink  frame,
  input  logic        full,
  output logic        push,
  output frame_desc_t desc
);

  logic [LEN_W-1:0] plen_sat;

  assign frame.ready = !full;
  assign push        = frame.valid && !full;

  // Payload length saturates at one frame's worth of bytes.
  assign plen_sat = (frame.payload_len > LEN_W'(FRAME_BYTES)) ? LEN_W'(FRAME_BYTES)
                                                             : frame.payload_len;

  always_comb begin
    desc.seq        = frame.seq_num;
    desc.bad        = frame.frame_bad;
    desc.eot        = frame.end_of_tx;
    desc.offset     = OFFSET_W'(frame.seq_num) << FRAME_SHIFT;
    desc.eot_length = (FLUSH_W'(frame.seq_num) << FRAME_SHIFT) + FLUSH_W'(plen_sat);
  end

endmodule

@@ rtl/srrw_queue.sv @@
module srrw_queue import srrw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_desc_t push_data,
  output logic        full,
  input  logic        pop,
  output frame_desc_t pop_data,
  output logic        empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_desc_t        slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/srrw_back.sv @@
module srrw_back import srrw_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  srrw_cfg_if.sink      cfg,
  input  logic          empty,
  input  frame_desc_t   desc,
  output logic          pop,
  srrw_result_if.source result
);

  localparam int IDX_W   = $clog2(WINDOW_MAX);
  localparam int SHIFT_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W   = NEXT_W + 1;

  logic [WIN_W-1:0]      win, win_next;
  logic [FRAMES_W-1:0]   frames, frames_next;
  logic [WINDOW_MAX-1:0] mask, mask_next;
  logic [NEXT_W-1:0]     next_exp, next_exp_next;
  logic [FRAMES_W-1:0]   limit, limit_next;
  logic [FLUSH_W-1:0]    length, length_next;
  logic                  eot_seen, eot_seen_next;
  logic                  out_valid;
  result_t               res, res_next;

  logic                  cfg_fire;
  logic [NEXT_W-1:0]     seq9;
  logic                  in_window;
  logic                  in_order;
  logic                  later;
  logic [IDX_W-1:0]      idx;
  logic [WINDOW_MAX-1:0] upper, run_mask;
  logic [SHIFT_W-1:0]    shift;

  function automatic logic [WINDOW_MAX-1:0] keep_bits(input logic [WIN_W-1:0] w);
    logic [WINDOW_MAX-1:0] k;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      k[i] = (i < int'(w));
    end
    return k;
  endfunction

  function automatic logic [WIN_W-1:0] sat_window(input logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] r;
    if (v == '0) begin
      r = WIN_W'(1);
    end else if (v > WIN_W'(WINDOW_MAX)) begin
      r = WIN_W'(WINDOW_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [FRAMES_W-1:0] sat_frames(input logic [FRAMES_W-1:0] v);
    logic [FRAMES_W-1:0] r;
    if (v == '0) begin
      r = FRAMES_W'(1);
    end else if (v > FRAMES_W'(FRAMES_MAX)) begin
      r = FRAMES_W'(FRAMES_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;
  assign pop       = !empty && (!out_valid || result.ready) && !cfg_fire;

  // Classification against the current window.
  assign seq9      = NEXT_W'(desc.seq);
  assign in_window = !desc.bad &&
                     (CMP_W'(desc.seq) < (CMP_W'(next_exp) + CMP_W'(win)));
  assign in_order  = (seq9 == next_exp);
  assign later     = (seq9 > next_exp);
  assign idx       = IDX_W'(seq9 - next_exp);

  // Run of already received frames just past the expected one: adding one flips
  // the trailing ones and the zero above them, so the and leaves only that run.
  assign upper    = mask >> 1;
  assign run_mask = upper & ~(upper + WINDOW_MAX'(1));
  assign shift    = SHIFT_W'($countones(run_mask)) + SHIFT_W'(1);

  always_comb begin
    win_next      = win;
    frames_next   = frames;
    mask_next     = mask;
    next_exp_next = next_exp;
    limit_next    = limit;
    length_next   = length;
    eot_seen_next = eot_seen;
    res_next      = res;

    if (cfg_fire) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_WINDOW_SIZE: begin
          win_next  = sat_window(cfg.data[WIN_W-1:0]);
          mask_next = mask & keep_bits(sat_window(cfg.data[WIN_W-1:0]));
        end
        REG_FRAMES_PER_BUFFER: begin
          frames_next = sat_frames(cfg.data[FRAMES_W-1:0]);
          if (!eot_seen) begin
            limit_next  = sat_frames(cfg.data[FRAMES_W-1:0]);
            length_next = FLUSH_W'(sat_frames(cfg.data[FRAMES_W-1:0])) << FRAME_SHIFT;
          end
        end
        default: begin
        end
      endcase
    end else if (pop) begin
      res_next.ack_seq         = desc.seq;
      res_next.ack_negative    = desc.bad;
      res_next.store_enable    = 1'b0;
      res_next.store_offset    = '0;
      res_next.buffer_complete = 1'b0;
      res_next.flush_length    = '0;
      res_next.transfer_done   = 1'b0;

      if (in_window) begin
        if (in_order) begin
          res_next.store_enable = 1'b1;
          res_next.store_offset = desc.offset;
          mask_next             = (mask >> shift) & keep_bits(win);
          next_exp_next         = next_exp + NEXT_W'(shift);
        end else if (later && !mask[idx]) begin
          res_next.store_enable = 1'b1;
          res_next.store_offset = desc.offset;
          mask_next             = mask | (WINDOW_MAX'(1) << idx);
        end
        if (desc.eot) begin
          length_next   = desc.eot_length;
          limit_next    = FRAMES_W'(seq9 + NEXT_W'(1));
          eot_seen_next = 1'b1;
        end
      end

      if (NEXT_W'(next_exp_next) >= NEXT_W'(limit_next)) begin
        res_next.buffer_complete = 1'b1;
        res_next.flush_length    = length_next;
        res_next.transfer_done   = eot_seen_next;
        mask_next                = '0;
        next_exp_next            = '0;
        eot_seen_next            = 1'b0;
        limit_next               = frames;
        length_next              = FLUSH_W'(frames) << FRAME_SHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= WIN_W'(4);
      frames    <= FRAMES_W'(1);
      mask      <= '0;
      next_exp  <= '0;
      limit     <= FRAMES_W'(1);
      length    <= FLUSH_W'(1) << FRAME_SHIFT;
      eot_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      win      <= win_next;
      frames   <= frames_next;
      mask     <= mask_next;
      next_exp <= next_exp_next;
      limit    <= limit_next;
      length   <= length_next;
      eot_seen <= eot_seen_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.ack_seq         = res.ack_seq;
  assign result.ack_negative    = res.ack_negative;
  assign result.store_enable    = res.store_enable;
  assign result.store_offset    = res.store_offset;
  assign result.buffer_complete = res.buffer_complete;
  assign result.flush_length    = res.flush_length;
  assign result.transfer_done   = res.transfer_done;

endmodule
